// File: sv/rlsc_pkg.sv
// Package for the reference line smoothing cost block.
// Holds widths, defaults, register indexes, sequencer types and shared functions.
// No dependencies.
package rlsc_pkg;

  localparam int DEF_MAX_POINTS  = 1024;
  localparam int DEF_COORD_WIDTH = 32;

  localparam int FIELD_W   = 32;
  localparam int WEIGHT_W  = 16;
  localparam int DIFF_W    = 34;
  localparam int CFG_IDX_W = 3;
  localparam int MUL_W     = 32;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd256;
  localparam logic signed [63:0]  I64_MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0]  I64_MIN      = 64'sh8000_0000_0000_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_DEVIATION  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHNESS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLACK      = 3'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_NORM,
    ST_WLO,
    ST_WHI,
    ST_WSUM,
    ST_ACC,
    ST_SLK_MUL,
    ST_SLK_ACC,
    ST_FIN
  } rlsc_state_t;

  typedef enum logic [1:0] {
    TERM_DEV,
    TERM_LEN,
    TERM_SMO
  } rlsc_term_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_SQX,
    MUL_SQY,
    MUL_WLO,
    MUL_WHI,
    MUL_SLK
  } rlsc_mul_op_t;

  typedef enum logic [1:0] {
    NORM_HOLD,
    NORM_LOAD,
    NORM_ADD
  } rlsc_norm_op_t;

  typedef struct packed {
    logic in_valid;
    logic has_len;
    logic has_smo;
    logic slack_on;
    logic out_free;
  } rlsc_status_t;

  typedef struct packed {
    logic          in_ready;
    rlsc_term_t    term;
    rlsc_mul_op_t  mul_op;
    rlsc_norm_op_t norm_op;
    logic          curv_ld;
    logic          lo_ld;
    logic          wsum_ld;
    logic          acc_term;
    logic          acc_slack;
    logic          finish;
  } rlsc_ctrl_t;

  function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] d);
    logic [DIFF_W-1:0] m;
    m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    return m;
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) begin
      return s[64] ? I64_MIN : I64_MAX;
    end
    return s[63:0];
  endfunction

endpackage

// File: sv/rlsc_if.sv
// Channel interfaces for the reference line smoothing cost block.
// Input point channel and result channel, valid/ready handshake.
// Depends on rlsc_pkg.
interface rlsc_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [rlsc_pkg::FIELD_W-1:0] point_x;
  logic signed [rlsc_pkg::FIELD_W-1:0] point_y;
  logic signed [rlsc_pkg::FIELD_W-1:0] ref_x;
  logic signed [rlsc_pkg::FIELD_W-1:0] ref_y;
  logic signed [rlsc_pkg::FIELD_W-1:0] slack_value;
  logic                               slack_present;
  logic                               last_point;

  modport source (output valid, point_x, point_y, ref_x, ref_y, slack_value,
                  slack_present, last_point, input ready);
  modport sink (input valid, point_x, point_y, ref_x, ref_y, slack_value,
                slack_present, last_point, output ready);
endinterface

interface rlsc_out_if;
  logic               valid;
  logic               ready;
  logic [62:0]        curvature_value;
  logic               curvature_valid;
  logic signed [63:0] total_cost;
  logic               cost_valid;

  modport source (output valid, curvature_value, curvature_valid, total_cost, cost_valid,
                  input ready);
  modport sink (input valid, curvature_value, curvature_valid, total_cost, cost_valid,
                output ready);
endinterface

// File: sv/rlsc_mul.sv
// Shared 32x32 unsigned multiplier with registered product.
// Used for squares, weight products and the slack product.
// Depends on rlsc_pkg.
module rlsc_mul (
  input  logic                           clk,
  input  logic [rlsc_pkg::MUL_W-1:0]     a,
  input  logic [rlsc_pkg::MUL_W-1:0]     b,
  output logic [2*rlsc_pkg::MUL_W-1:0]   prod_r
);

  logic [2*rlsc_pkg::MUL_W-1:0] prod_nxt;

  assign prod_nxt = (2*rlsc_pkg::MUL_W)'(a) * (2*rlsc_pkg::MUL_W)'(b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// File: sv/rlsc_seq.sv
// Sequencer for the reference line smoothing cost block.
// Walks each point through the deviation term, then any length, smoothness and slack terms.
// Depends on rlsc_pkg.
module rlsc_seq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rlsc_pkg::rlsc_status_t status,
  output rlsc_pkg::rlsc_ctrl_t   ctrl
);

  rlsc_pkg::rlsc_state_t state_r, state_nxt;
  rlsc_pkg::rlsc_term_t  term_r, term_nxt;
  rlsc_pkg::rlsc_state_t tail_state;

  assign tail_state = status.slack_on ? rlsc_pkg::ST_SLK_MUL : rlsc_pkg::ST_FIN;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rlsc_pkg::ST_IDLE;
      term_r  <= rlsc_pkg::TERM_DEV;
    end else begin
      state_r <= state_nxt;
      term_r  <= term_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    term_nxt  = term_r;
    case (state_r)
      rlsc_pkg::ST_IDLE: begin
        if (status.in_valid) begin
          state_nxt = rlsc_pkg::ST_SQX;
          term_nxt  = rlsc_pkg::TERM_DEV;
        end
      end
      rlsc_pkg::ST_SQX:     state_nxt = rlsc_pkg::ST_SQY;
      rlsc_pkg::ST_SQY:     state_nxt = rlsc_pkg::ST_NORM;
      rlsc_pkg::ST_NORM:    state_nxt = rlsc_pkg::ST_WLO;
      rlsc_pkg::ST_WLO:     state_nxt = rlsc_pkg::ST_WHI;
      rlsc_pkg::ST_WHI:     state_nxt = rlsc_pkg::ST_WSUM;
      rlsc_pkg::ST_WSUM:    state_nxt = rlsc_pkg::ST_ACC;
      rlsc_pkg::ST_ACC: begin
        case (term_r)
          rlsc_pkg::TERM_DEV: begin
            if (status.has_len) begin
              term_nxt  = rlsc_pkg::TERM_LEN;
              state_nxt = rlsc_pkg::ST_SQX;
            end else begin
              state_nxt = tail_state;
            end
          end
          rlsc_pkg::TERM_LEN: begin
            if (status.has_smo) begin
              term_nxt  = rlsc_pkg::TERM_SMO;
              state_nxt = rlsc_pkg::ST_SQX;
            end else begin
              state_nxt = tail_state;
            end
          end
          default: state_nxt = tail_state;
        endcase
      end
      rlsc_pkg::ST_SLK_MUL: state_nxt = rlsc_pkg::ST_SLK_ACC;
      rlsc_pkg::ST_SLK_ACC: state_nxt = rlsc_pkg::ST_FIN;
      rlsc_pkg::ST_FIN: begin
        if (status.out_free) begin
          state_nxt = rlsc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rlsc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl           = '0;
    ctrl.term      = term_r;
    ctrl.mul_op    = rlsc_pkg::MUL_NONE;
    ctrl.norm_op   = rlsc_pkg::NORM_HOLD;
    case (state_r)
      rlsc_pkg::ST_IDLE:    ctrl.in_ready = 1'b1;
      rlsc_pkg::ST_SQX:     ctrl.mul_op = rlsc_pkg::MUL_SQX;
      rlsc_pkg::ST_SQY: begin
        ctrl.mul_op  = rlsc_pkg::MUL_SQY;
        ctrl.norm_op = rlsc_pkg::NORM_LOAD;
      end
      rlsc_pkg::ST_NORM:    ctrl.norm_op = rlsc_pkg::NORM_ADD;
      rlsc_pkg::ST_WLO: begin
        ctrl.mul_op  = rlsc_pkg::MUL_WLO;
        ctrl.curv_ld = (term_r == rlsc_pkg::TERM_SMO);
      end
      rlsc_pkg::ST_WHI: begin
        ctrl.mul_op = rlsc_pkg::MUL_WHI;
        ctrl.lo_ld  = 1'b1;
      end
      rlsc_pkg::ST_WSUM:    ctrl.wsum_ld = 1'b1;
      rlsc_pkg::ST_ACC:     ctrl.acc_term = 1'b1;
      rlsc_pkg::ST_SLK_MUL: ctrl.mul_op = rlsc_pkg::MUL_SLK;
      rlsc_pkg::ST_SLK_ACC: ctrl.acc_slack = 1'b1;
      rlsc_pkg::ST_FIN:     ctrl.finish = status.out_free;
      default: ctrl.in_ready = 1'b0;
    endcase
  end

endmodule

// File: sv/reference_line_smoothing_cost_top.sv
// Top level of the reference line smoothing cost block: datapath, weights and output register.
// Instantiates rlsc_seq and rlsc_mul; channels are rlsc_in_if and rlsc_out_if.
// Depends on rlsc_pkg and rlsc_if.
//
// One point transaction in, one result transaction out. All products go through a single
// registered 32x32 multiplier under a small sequencer. A point passes through T squared terms
// (1 for the first point of a line, 2 for the second, 3 from the third on) and then, when slack
// is present, through the slack product and its accumulate step. Each squared term takes four
// multiplier passes (two squares, low and high halves of the weight product) plus norm, scaling
// and accumulate steps. The block takes no new point until it is through with the last one.
// The result sits in an output register; a new point is taken while it waits, and that point
// holds in its last step until the register is free. The user must write weights through cfg_*
// only while the block is idle; the block itself does not enforce this.
module reference_line_smoothing_cost_top #(
  parameter int MAX_POINTS  = rlsc_pkg::DEF_MAX_POINTS,
  parameter int COORD_WIDTH = rlsc_pkg::DEF_COORD_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  rlsc_in_if.sink                           in_ch,
  rlsc_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [rlsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rlsc_pkg::WEIGHT_W-1:0]     cfg_data
);

  localparam int PS_W = $clog2(MAX_POINTS + 1);
  localparam int DW   = rlsc_pkg::DIFF_W;
  localparam int MW   = rlsc_pkg::MUL_W;
  localparam int WW   = rlsc_pkg::WEIGHT_W;

  rlsc_pkg::rlsc_status_t status;
  rlsc_pkg::rlsc_ctrl_t   ctrl;

  logic [WW-1:0] w_dev_r, w_smo_r, w_len_r, w_slk_r;

  logic signed [COORD_WIDTH-1:0] px_r, py_r, rx_r, ry_r;
  logic signed [COORD_WIDTH-1:0] p0x_r, p0y_r, p1x_r, p1y_r;
  logic signed [31:0]            slack_r;
  logic                          slack_on_r, last_r;
  logic [PS_W-1:0]               points_seen_r;
  logic signed [63:0]            cost_sum_r, acc_r, wterm_r;
  logic [63:0]                   norm_r;
  logic [47:0]                   lo_r;
  logic [62:0]                   curv_r;

  logic              out_valid_r, curv_valid_r, cost_valid_r;
  logic [62:0]       out_curv_r;
  logic signed [63:0] out_cost_r;

  logic signed [DW-1:0] pxe, pye, rxe, rye, p0xe, p0ye, p1xe, p1ye;
  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0]        magx, magy;
  logic                 overx, overy;
  logic [WW-1:0]        w_sel;
  logic [MW-1:0]        mul_a, mul_b;
  logic [2*MW-1:0]      prod_r;
  logic [64:0]          norm_sum;
  logic [63:0]          sqy;
  logic [48:0]          upper;
  logic [80:0]          full;
  logic [72:0]          scaled;
  logic [31:0]          slack_mag;
  logic [55:0]          slack_term_mag;
  logic signed [63:0]   slack_term;
  logic                 accept;

  assign accept = in_ch.valid && ctrl.in_ready;
  assign in_ch.ready = ctrl.in_ready;

  assign status.in_valid = in_ch.valid;
  assign status.has_len  = (points_seen_r != '0);
  assign status.has_smo  = (points_seen_r >= PS_W'(2));
  assign status.slack_on = slack_on_r;
  assign status.out_free = !out_valid_r || out_ch.ready;

  rlsc_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  rlsc_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_dev_r <= rlsc_pkg::WEIGHT_RESET;
      w_smo_r <= rlsc_pkg::WEIGHT_RESET;
      w_len_r <= rlsc_pkg::WEIGHT_RESET;
      w_slk_r <= rlsc_pkg::WEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rlsc_pkg::CFG_DEVIATION:  w_dev_r <= cfg_data;
        rlsc_pkg::CFG_SMOOTHNESS: w_smo_r <= cfg_data;
        rlsc_pkg::CFG_LENGTH:     w_len_r <= cfg_data;
        rlsc_pkg::CFG_SLACK:      w_slk_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // coordinate differences for the current term
  assign pxe  = DW'(px_r);
  assign pye  = DW'(py_r);
  assign rxe  = DW'(rx_r);
  assign rye  = DW'(ry_r);
  assign p0xe = DW'(p0x_r);
  assign p0ye = DW'(p0y_r);
  assign p1xe = DW'(p1x_r);
  assign p1ye = DW'(p1y_r);

  always_comb begin
    case (ctrl.term)
      rlsc_pkg::TERM_DEV: begin
        dx    = pxe - rxe;
        dy    = pye - rye;
        w_sel = w_dev_r;
      end
      rlsc_pkg::TERM_LEN: begin
        dx    = pxe - p0xe;
        dy    = pye - p0ye;
        w_sel = w_len_r;
      end
      default: begin
        dx    = p1xe + pxe - (p0xe <<< 1);
        dy    = p1ye + pye - (p0ye <<< 1);
        w_sel = w_smo_r;
      end
    endcase
  end

  assign magx  = rlsc_pkg::abs_diff(dx);
  assign magy  = rlsc_pkg::abs_diff(dy);
  assign overx = |magx[DW-1:MW];
  assign overy = |magy[DW-1:MW];

  assign slack_mag = slack_r[31] ? 32'(-slack_r) : 32'(slack_r);

  always_comb begin
    case (ctrl.mul_op)
      rlsc_pkg::MUL_SQX: begin
        mul_a = magx[MW-1:0];
        mul_b = magx[MW-1:0];
      end
      rlsc_pkg::MUL_SQY: begin
        mul_a = magy[MW-1:0];
        mul_b = magy[MW-1:0];
      end
      rlsc_pkg::MUL_WLO: begin
        mul_a = norm_r[31:0];
        mul_b = MW'(w_sel);
      end
      rlsc_pkg::MUL_WHI: begin
        mul_a = norm_r[63:32];
        mul_b = MW'(w_sel);
      end
      rlsc_pkg::MUL_SLK: begin
        mul_a = slack_mag;
        mul_b = MW'(w_slk_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // squared norm, weight scaling and slack term
  assign sqy      = overy ? {64{1'b1}} : prod_r;
  assign norm_sum = 65'(norm_r) + 65'(sqy);

  assign upper  = 49'(prod_r[47:0]) + 49'(lo_r[47:32]);
  assign full   = {upper, lo_r[31:0]};
  assign scaled = full[80:8];

  assign slack_term_mag = {prod_r[47:0], 8'h00};
  assign slack_term     = slack_r[31] ? -$signed(64'(slack_term_mag))
                                      : $signed(64'(slack_term_mag));

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r       <= in_ch.point_x[COORD_WIDTH-1:0];
      py_r       <= in_ch.point_y[COORD_WIDTH-1:0];
      rx_r       <= in_ch.ref_x[COORD_WIDTH-1:0];
      ry_r       <= in_ch.ref_y[COORD_WIDTH-1:0];
      slack_r    <= in_ch.slack_value;
      slack_on_r <= in_ch.slack_present;
      last_r     <= in_ch.last_point;
    end
    case (ctrl.norm_op)
      rlsc_pkg::NORM_LOAD: norm_r <= overx ? {64{1'b1}} : prod_r;
      rlsc_pkg::NORM_ADD:  norm_r <= norm_sum[64] ? {64{1'b1}} : norm_sum[63:0];
      default: ;
    endcase
    if (ctrl.curv_ld) begin
      curv_r <= norm_r[63] ? {63{1'b1}} : norm_r[62:0];
    end
    if (ctrl.lo_ld) begin
      lo_r <= prod_r[47:0];
    end
    if (ctrl.wsum_ld) begin
      wterm_r <= (|scaled[72:63]) ? rlsc_pkg::I64_MAX : $signed({1'b0, scaled[62:0]});
    end
    if (accept) begin
      acc_r <= cost_sum_r;
    end else if (ctrl.acc_term) begin
      acc_r <= rlsc_pkg::sat_add64(acc_r, wterm_r);
    end else if (ctrl.acc_slack) begin
      acc_r <= rlsc_pkg::sat_add64(acc_r, slack_term);
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0x_r         <= '0;
      p0y_r         <= '0;
      p1x_r         <= '0;
      p1y_r         <= '0;
      points_seen_r <= '0;
      cost_sum_r    <= '0;
    end else if (ctrl.finish) begin
      if (last_r) begin
        p0x_r         <= '0;
        p0y_r         <= '0;
        p1x_r         <= '0;
        p1y_r         <= '0;
        points_seen_r <= '0;
        cost_sum_r    <= '0;
      end else begin
        p1x_r      <= p0x_r;
        p1y_r      <= p0y_r;
        p0x_r      <= px_r;
        p0y_r      <= py_r;
        cost_sum_r <= acc_r;
        if (points_seen_r < PS_W'(MAX_POINTS)) begin
          points_seen_r <= points_seen_r + PS_W'(1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      out_curv_r   <= status.has_smo ? curv_r : '0;
      curv_valid_r <= status.has_smo;
      out_cost_r   <= last_r ? acc_r : '0;
      cost_valid_r <= last_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.curvature_value = out_curv_r;
  assign out_ch.curvature_valid = curv_valid_r;
  assign out_ch.total_cost      = out_cost_r;
  assign out_ch.cost_valid      = cost_valid_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ch.ready)
    else $error("input taken again right after a transaction");

  a_finish_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.finish |-> (!out_valid_r || out_ch.ready))
    else $error("result overwrites an untaken transaction");

  a_line_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.finish && last_r) |=> (points_seen_r == '0 && cost_sum_r == '0))
    else $error("line state not cleared after last point");

  a_points_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    points_seen_r <= PS_W'(MAX_POINTS))
    else $error("point count past its limit");

endmodule
